// File: rtl/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg: shared types for the summed-volume table box counter
// Payload structs, register indexes and controller/datapath link structs.
// ----------------------------------------------------------------------------
package svt_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int CountW = 15;

  typedef struct packed {
    logic       opcode;
    logic       cell_hit;
    logic [4:0] centre_x;
    logic [4:0] centre_y;
    logic [4:0] centre_z;
    logic [4:0] radius;
  } in_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              ready_res;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       rd;
    logic [2:0] corner;
    logic       fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
  } sts_t;

endpackage

// File: rtl/svt_ctrl.sv
// ----------------------------------------------------------------------------
// svt_ctrl: sequencing state machine
// Takes an item, steps the eight corner reads unless the item is skipped, then hands off the result.
// ----------------------------------------------------------------------------
module svt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  svt_pkg::sts_t sts,
  output svt_pkg::cmd_t cmd
);
  import svt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state, state_next;
  logic [2:0] corner, corner_next;
  logic       out_valid_next;

  // next state and commands
  always_comb begin
    state_next  = state;
    corner_next = corner;
    cmd         = '0;
    cmd.corner  = corner;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          corner_next = '0;
          state_next  = sts.skip ? S_FIN : S_READ;
        end
      end
      S_READ: begin
        cmd.rd      = 1'b1;
        corner_next = corner + 3'd1;
        if (corner == 3'd7) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output valid holds until taken
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.fin) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      corner    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      corner    <= corner_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/svt_dp.sv
// ----------------------------------------------------------------------------
// svt_dp: table datapath
// Size registers, load counters, prefix store and signed corner accumulator.
// ----------------------------------------------------------------------------
module svt_dp #(
  parameter int MAX_AXIS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [5:0]     cfg_data,
  input  svt_pkg::in_t   in,
  input  svt_pkg::cmd_t  cmd,
  output svt_pkg::sts_t  sts,
  output svt_pkg::out_t  out
);
  import svt_pkg::*;

  localparam int CW    = (MAX_AXIS > 2) ? $clog2(MAX_AXIS) : 1;
  localparam int DEPTH = 1 << (3 * CW);
  localparam int EW    = 8;

  function automatic logic [CW-1:0] eff_m1(input logic [5:0] v);
    logic [EW-1:0] w;
    w = {2'b00, v};
    if (w < 8'd2) return CW'(1);
    else if (w > EW'(MAX_AXIS)) return CW'(MAX_AXIS - 1);
    else return CW'(w - 8'd1);
  endfunction

  // upper coordinate clamp for one query axis
  function automatic logic [CW-1:0] clamp_up(input logic [CW-1:0] c,
                                             input logic [4:0] r,
                                             input logic [CW-1:0] m);
    logic [EW-1:0] s;
    s = EW'(c) + EW'(r);
    return (s > EW'(m)) ? m : CW'(s);
  endfunction

  function automatic logic [CW-1:0] clamp_lo(input logic [CW-1:0] c,
                                             input logic [4:0] r);
    return (EW'(c) > EW'(r)) ? CW'(EW'(c) - EW'(r)) : '0;
  endfunction

  function automatic logic [CW-1:0] clamp_c(input logic [4:0] c,
                                            input logic [CW-1:0] m);
    return (EW'(c) > EW'(m)) ? m : CW'(c);
  endfunction

  logic [CW-1:0] ax_m1, ay_m1, az_m1;
  logic [CW-1:0] load_x, load_y, load_z;
  logic          table_full;
  logic [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic          is_load, hit, skip;
  logic [CountW-1:0] acc, mem_q, term, result;
  logic [CountW-1:0] mem [DEPTH];
  logic [3*CW-1:0]   rd_addr, wr_addr;
  logic [CW-1:0]     sel_x, sel_y, sel_z;
  logic              acc_en, zero_d, neg_d;
  logic [2:0]        corner_d;
  logic [CW-1:0]     cx, cy, cz;
  logic [CW:0]       nx, ny, nz;
  logic              wrap_x, wrap_y, wrap_z;

  assign sts.skip = (in.opcode == OP_LOAD) ? table_full : !table_full;

  // corner select: a set bit picks the lower coordinate
  assign sel_x   = cmd.corner[0] ? lo_x : hi_x;
  assign sel_y   = cmd.corner[1] ? lo_y : hi_y;
  assign sel_z   = cmd.corner[2] ? lo_z : hi_z;
  assign rd_addr = {sel_z, sel_y, sel_x};
  assign wr_addr = {hi_z, hi_y, hi_x};

  // clamped query centre
  assign cx = clamp_c(in.centre_x, ax_m1);
  assign cy = clamp_c(in.centre_y, ay_m1);
  assign cz = clamp_c(in.centre_z, az_m1);

  // prefix store, one write port and one read port
  always_ff @(posedge clk) begin
    if (cmd.fin && is_load && !skip) mem[wr_addr] <= result;
    mem_q <= mem[rd_addr];
  end

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (rst) acc_en <= 1'b0;
    else acc_en <= cmd.rd;
    zero_d   <= (sel_x == '0) || (sel_y == '0) || (sel_z == '0);
    neg_d    <= (^cmd.corner) ^ is_load;
    corner_d <= cmd.corner;
  end

  // load skips the corner it is about to write
  assign term = (zero_d || (is_load && corner_d == 3'd0)) ? '0 : mem_q;

  assign result = skip ? '0 : (acc + CountW'(is_load && hit));

  // next load position
  assign nx     = {1'b0, load_x} + 1'b1;
  assign ny     = {1'b0, load_y} + 1'b1;
  assign nz     = {1'b0, load_z} + 1'b1;
  assign wrap_x = nx >= {1'b0, ax_m1};
  assign wrap_y = ny >= {1'b0, ay_m1};
  assign wrap_z = nz >= {1'b0, az_m1};

  // item capture and accumulate
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_load <= (in.opcode == OP_LOAD);
      hit     <= in.cell_hit;
      skip    <= sts.skip;
      acc     <= '0;
      if (in.opcode == OP_LOAD) begin
        lo_x <= load_x;  hi_x <= CW'(nx);
        lo_y <= load_y;  hi_y <= CW'(ny);
        lo_z <= load_z;  hi_z <= CW'(nz);
      end else begin
        lo_x <= clamp_lo(cx, in.radius);  hi_x <= clamp_up(cx, in.radius, ax_m1);
        lo_y <= clamp_lo(cy, in.radius);  hi_y <= clamp_up(cy, in.radius, ay_m1);
        lo_z <= clamp_lo(cz, in.radius);  hi_z <= clamp_up(cz, in.radius, az_m1);
      end
    end else if (acc_en) begin
      acc <= neg_d ? (acc - term) : (acc + term);
    end
  end

  // sizes, load counters and table-full flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ax_m1      <= eff_m1(6'd32);
      ay_m1      <= eff_m1(6'd32);
      az_m1      <= eff_m1(6'd32);
      load_x     <= '0;
      load_y     <= '0;
      load_z     <= '0;
      table_full <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y ||
                            cfg_index == CFG_SIZE_Z)) begin
      if (cfg_index == CFG_SIZE_X) ax_m1 <= eff_m1(cfg_data);
      if (cfg_index == CFG_SIZE_Y) ay_m1 <= eff_m1(cfg_data);
      if (cfg_index == CFG_SIZE_Z) az_m1 <= eff_m1(cfg_data);
      load_x     <= '0;
      load_y     <= '0;
      load_z     <= '0;
      table_full <= 1'b0;
    end else if (cmd.fin && is_load && !skip) begin
      if (!wrap_x) begin
        load_x <= CW'(nx);
      end else begin
        load_x <= '0;
        if (!wrap_y) begin
          load_y <= CW'(ny);
        end else begin
          load_y <= '0;
          if (!wrap_z) begin
            load_z <= CW'(nz);
          end else begin
            load_z     <= '0;
            table_full <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out.count     <= result;
      out.ready_res <= table_full || (is_load && !skip && wrap_x && wrap_y && wrap_z);
    end
  end

endmodule

// File: rtl/summed_volume_table_box_count_unit.sv
// ----------------------------------------------------------------------------
// summed_volume_table_box_count_unit: 3d summed-volume table box counter
// Loads cell flags into a prefix table and answers clamped cube counts.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in       in   in_valid / in_ready   svt_pkg::in_t
//  out      out  out_valid / out_ready svt_pkg::out_t
//  cfg      in   cfg_we                cfg_index, cfg_data
//
// a load or query steps through capture, eight corner reads from the
// prefix store (one read and one write port), a drain state for the read latency and a result state;
// an item that changes nothing (load after full, query before full) skips the reads.
// reset is synchronous; the table holds no valid state until reloaded.
// the next item is taken while a result waits; a stalled result holds the
// final stage until the output side takes it.
module summed_volume_table_box_count_unit #(
  parameter int MAX_AXIS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [5:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  svt_pkg::in_t  in,
  output logic          out_valid,
  input  logic          out_ready,
  output svt_pkg::out_t out
);
  import svt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  svt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  svt_dp #(.MAX_AXIS(MAX_AXIS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in        (in),
    .cmd       (cmd),
    .sts       (sts),
    .out       (out)
  );

endmodule

// File: rtl/svt_chk.sv
// ----------------------------------------------------------------------------
// svt_chk: port checker
// Watches the top level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module svt_chk (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input svt_pkg::out_t out
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  // reset clears the result side
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // no result appears right after an item is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind summed_volume_table_box_count_unit svt_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out       (out)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the summed-volume table box counter
// Loads random flag grids at several sizes, queries cubes, and compares each
// result with a behavioral prediction kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb;
  import svt_pkg::*;

  localparam int AXIS = 32;
  localparam int CYCLE_LIMIT = 1500000;

  // scoreboard: predicted table, load position and pending results
  class svt_scoreboard;
    int unsigned vol[AXIS*AXIS*AXIS];
    int unsigned sz_x, sz_y, sz_z;
    int unsigned lx, ly, lz;
    bit full;
    out_t pending[$];
    int errors;

    function new();
      sz_x = 32; sz_y = 32; sz_z = 32;
      restart();
      errors = 0;
    endfunction

    function void restart();
      lx = 0; ly = 0; lz = 0; full = 0;
    endfunction

    function int unsigned axis_of(int unsigned v);
      if (v < 2) return 2;
      if (v > AXIS) return AXIS;
      return v;
    endfunction

    function int unsigned vert(int unsigned x, int unsigned y, int unsigned z);
      if (x == 0 || y == 0 || z == 0) return 0;
      if (x >= AXIS || y >= AXIS || z >= AXIS) return 0;
      return vol[x + AXIS*(y + AXIS*z)];
    endfunction

    function void set_size(logic [1:0] idx, logic [5:0] v);
      if (idx == CFG_SIZE_X) sz_x = v;
      else if (idx == CFG_SIZE_Y) sz_y = v;
      else if (idx == CFG_SIZE_Z) sz_z = v;
      else return;
      restart();
    endfunction

    function int unsigned hi(int unsigned v, int unsigned h);
      return v > h ? h : v;
    endfunction

    // note an accepted item and queue its expected result
    function void note_item(in_t it);
      int unsigned ax, ay, az, x, y, z, s, r, cx, cy, cz, bx, by, bz, ux, uy, uz;
      out_t e;
      ax = axis_of(sz_x); ay = axis_of(sz_y); az = axis_of(sz_z);
      s = 0;
      if (it.opcode == OP_LOAD) begin
        if (!full) begin
          x = lx + 1; y = ly + 1; z = lz + 1;
          s = vert(x-1, y, z) + vert(x, y-1, z) + vert(x, y, z-1)
            - vert(x-1, y-1, z) - vert(x, y-1, z-1) - vert(x-1, y, z-1)
            + vert(x-1, y-1, z-1) + it.cell_hit;
          s = s & 32'h7fff;
          vol[x + AXIS*(y + AXIS*z)] = s;
          lx++;
          if (lx >= ax - 1) begin
            lx = 0; ly++;
            if (ly >= ay - 1) begin
              ly = 0; lz++;
              if (lz >= az - 1) begin
                lz = 0; full = 1;
              end
            end
          end
        end
      end else if (full) begin
        r = it.radius;
        cx = hi(it.centre_x, ax - 1); cy = hi(it.centre_y, ay - 1);
        cz = hi(it.centre_z, az - 1);
        bx = cx > r ? cx - r : 0; by = cy > r ? cy - r : 0; bz = cz > r ? cz - r : 0;
        ux = hi(cx + r, ax - 1); uy = hi(cy + r, ay - 1); uz = hi(cz + r, az - 1);
        s = vert(ux, uy, uz) - vert(bx, uy, uz) - vert(ux, uy, bz) + vert(bx, uy, bz)
          - vert(ux, by, uz) + vert(bx, by, uz) + vert(ux, by, bz) - vert(bx, by, bz);
        s = s & 32'h7fff;
      end
      e.count = s[14:0];
      e.ready_res = full;
      pending.push_back(e);
    endfunction

    // compare a result with the oldest expectation
    task check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.count !== e.count)
        report($sformatf("count got %0d want %0d", got.count, e.count));
      if (got.ready_res !== e.ready_res)
        report($sformatf("ready_res got %0b want %0b", got.ready_res, e.ready_res));
    endtask

    task report(string msg);
      errors++;
      $display("tb: mismatch: %s", msg);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  in_t in_item = '0;
  out_t out_item;

  svt_scoreboard board = new();
  int send_idle = 0, recv_idle = 0;
  int cycles = 0;

  summed_volume_table_box_count_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in(in_item), .out_valid(out_valid), .out_ready(out_ready), .out(out_item)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // sample handshakes at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (!rst && in_valid && in_ready) board.note_item(in_item);
    if (!rst && out_valid && out_ready) board.check_result(out_item);
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle);

  // send one item, holding it until taken
  task automatic send_item(in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_item <= it;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic write_size(logic [1:0] idx, logic [5:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.set_size(idx, v);
  endtask

  // wait for every result, then the block's own latency
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_grid(logic [5:0] x, logic [5:0] y, logic [5:0] z);
    drain();
    write_size(CFG_SIZE_X, x);
    write_size(CFG_SIZE_Y, y);
    write_size(CFG_SIZE_Z, z);
  endtask

  // random payload bits
  function automatic in_t rand_item();
    logic [31:0] rnd;
    rnd = $urandom;
    return rnd[$bits(in_t)-1:0];
  endfunction

  function automatic in_t rand_query();
    in_t q;
    q = rand_item();
    q.opcode = OP_QUERY;
    if ($urandom_range(3) == 0) q.radius = 5'($urandom_range(3));
    return q;
  endfunction

  // load a whole grid with random density, then a batch of queries with some extra loads
  task automatic load_and_query(int nq);
    in_t it;
    int n, dens;
    n = (board.axis_of(board.sz_x) - 1) * (board.axis_of(board.sz_y) - 1)
      * (board.axis_of(board.sz_z) - 1);
    dens = $urandom_range(100);
    for (int i = 0; i < n; i++) begin
      it = rand_item();
      it.opcode = OP_LOAD;
      it.cell_hit = ($urandom_range(99) < dens);
      send_item(it);
    end
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(9) == 0) begin
        it = rand_item();
        it.opcode = OP_LOAD;
        send_item(it);
      end else send_item(rand_query());
    end
  endtask

  task automatic run_phase(int items);
    int done;
    done = 0;
    while (done < items) begin
      case ($urandom_range(3))
        0: set_grid(6'($urandom_range(2, 5)), 6'($urandom_range(2, 5)),
                    6'($urandom_range(2, 5)));
        1: set_grid(6'($urandom_range(0, 63)), 2, 2);
        default: set_grid(6'($urandom_range(2, 8)), 6'($urandom_range(2, 8)),
                          6'($urandom_range(2, 4)));
      endcase
      load_and_query(40);
      done += 40 + (board.axis_of(board.sz_x) - 1) * (board.axis_of(board.sz_y) - 1)
            * (board.axis_of(board.sz_z) - 1);
    end
  endtask

  initial begin
    in_t it;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: query and load extremes on the reset-size grid and small grids, before and after full
    it = '0; it.opcode = OP_QUERY; it.centre_x = 31; it.centre_y = 31;
    it.centre_z = 31; it.radius = 31;
    send_item(it);
    set_grid(2, 2, 2);
    it = '0; it.opcode = OP_QUERY;
    send_item(it);
    it = '1; it.opcode = OP_LOAD;
    send_item(it);
    it = '0; send_item(it);
    it = '1; it.opcode = OP_QUERY; send_item(it);
    it = '0; it.opcode = OP_QUERY; send_item(it);
    set_grid(3, 3, 2);
    for (int i = 0; i < 4; i++) begin
      it = '0; it.cell_hit = 1; send_item(it);
    end
    it = '0; it.opcode = OP_QUERY; it.centre_x = 1; it.centre_y = 1; send_item(it);
    it.radius = 1; send_item(it);
    it.centre_x = 31; it.centre_y = 0; it.centre_z = 31; it.radius = 31; send_item(it);
    it = '1; send_item(it);

    // widest x axis once, most cells flagged
    set_grid(32, 4, 4);
    for (int i = 0; i < 31*3*3; i++) begin
      it = rand_item(); it.opcode = OP_LOAD; it.cell_hit = ($urandom_range(9) != 0);
      send_item(it);
    end
    for (int i = 0; i < 20; i++) send_item(rand_query());
    it = '1; send_item(it);
    it = '0; it.opcode = OP_QUERY; it.radius = 31; send_item(it);

    send_idle = 10; recv_idle = 76;
    run_phase(400);
    send_idle = 76; recv_idle = 10;
    run_phase(400);
    send_idle = 0; recv_idle = 0;
    run_phase(400);

    drain();
    if (board.errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

// File: summed_volume_table_box_count_unit.f
rtl/svt_pkg.sv
rtl/svt_ctrl.sv
rtl/svt_dp.sv
rtl/summed_volume_table_box_count_unit.sv
rtl/svt_chk.sv
dv/tb.sv
